/* sv/pfe_pkg.sv */
package pfe_pkg;

    localparam int SIDE       = 5;
    localparam int CODE_W     = 5;
    localparam int IDX_W      = $clog2(SIDE);
    localparam int KEY_ROW_W  = SIDE * CODE_W;
    localparam int KEY_PAIR_W = 2 * KEY_ROW_W;
    localparam int SQUARE_W   = SIDE * KEY_ROW_W;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 5;
    localparam int STATUS_W   = 2;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [IDX_W-1:0]  t_idx;

    // entry [row][col] sits at bit (row*SIDE+col)*CODE_W of the flat square
    typedef logic [SIDE-1:0][SIDE-1:0][CODE_W-1:0] t_square;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_SAME    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_ROWS01 = 2'd0,
        REG_ROWS23 = 2'd1,
        REG_ROW4   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic hit;
        t_idx row;
        t_idx col;
    } t_loc;

    typedef struct packed {
        t_status status;
        t_code   second;
        t_code   first;
    } t_result;

    function automatic t_idx wrap_inc(input t_idx i);
        t_idx n;
        if (i == t_idx'(SIDE - 1)) begin
            n = '0;
        end else begin
            n = i + t_idx'(1);
        end
        return n;
    endfunction

endpackage

/* sv/pfe_locate.sv */
module pfe_locate (
    input  pfe_pkg::t_square i_square,
    input  pfe_pkg::t_code   i_code,
    output pfe_pkg::t_loc    o_loc
);

    // later matches in row-major order override earlier ones
    always_comb begin
        o_loc = '0;
        for (int r = 0; r < pfe_pkg::SIDE; r++) begin
            for (int c = 0; c < pfe_pkg::SIDE; c++) begin
                if (i_square[r][c] == i_code) begin
                    o_loc.hit = 1'b1;
                    o_loc.row = pfe_pkg::t_idx'(r);
                    o_loc.col = pfe_pkg::t_idx'(c);
                end
            end
        end
    end

endmodule

/* sv/pfe_core.sv */
module pfe_core (
    input  pfe_pkg::t_square i_square,
    input  pfe_pkg::t_code   i_first,
    input  pfe_pkg::t_code   i_second,
    output pfe_pkg::t_result o_result
);

    pfe_pkg::t_loc loc_a;
    pfe_pkg::t_loc loc_b;

    pfe_locate u_loc_a (
        .i_square (i_square),
        .i_code   (i_first),
        .o_loc    (loc_a)
    );

    pfe_locate u_loc_b (
        .i_square (i_square),
        .i_code   (i_second),
        .o_loc    (loc_b)
    );

    always_comb begin
        o_result = '0;
        if (i_first == i_second) begin
            o_result.status = pfe_pkg::ST_SAME;
        end else if (!loc_a.hit || !loc_b.hit) begin
            o_result.status = pfe_pkg::ST_MISSING;
        end else begin
            o_result.status = pfe_pkg::ST_OK;
            if (loc_a.row == loc_b.row) begin
                o_result.first  = i_square[loc_a.row][pfe_pkg::wrap_inc(loc_a.col)];
                o_result.second = i_square[loc_b.row][pfe_pkg::wrap_inc(loc_b.col)];
            end else if (loc_a.col == loc_b.col) begin
                o_result.first  = i_square[pfe_pkg::wrap_inc(loc_a.row)][loc_a.col];
                o_result.second = i_square[pfe_pkg::wrap_inc(loc_b.row)][loc_b.col];
            end else begin
                // rectangle: swap columns
                o_result.first  = i_square[loc_a.row][loc_b.col];
                o_result.second = i_square[loc_b.row][loc_a.col];
            end
        end
    end

endmodule

/* sv/playfair_digraph_encrypt.sv */
// Playfair digraph encryptor, 5x5 key square.
// Input stream (s_axis_*): one item is a plaintext letter pair, taken on
//   tvalid & tready. Output stream (m_axis_*): one item per input, the two
//   cipher letters and a status (ok, identical letters, letter not in square).
// Key square: three APB registers, 64-bit data, byte addresses 0, 8, 16
//   (rows 0-1, rows 2-3, row 4), 5-bit letter codes, entry 0 lowest.
//   Write the square only while no item is in flight.
// Data path: an accepted item is captured in the input register; its result is
//   then loaded into the result register, whose valid flag drives tvalid.
// Throughput: one item per cycle unless the receiver stalls; the square is
//   searched by 25 parallel compares per letter between the two registers.
// Stall: while the receiver holds tready low the result register holds its
//   item; an empty input register takes one more item, then tready drops.
// Reset (synchronous, active low): both stages empty, key square all zero.
module playfair_digraph_encrypt (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pfe_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pfe_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pfe_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [4:0] first_letter, [9:5] second_letter, [15:10] zero
    input  logic [pfe_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [4:0] first_cipher, [9:5] second_cipher, [11:10] status, [15:12] zero
    output logic [pfe_pkg::TDATA_OUT_W-1:0]    m_axis_tdata
);

    // key square registers
    logic [pfe_pkg::KEY_PAIR_W-1:0] r_key01;
    logic [pfe_pkg::KEY_PAIR_W-1:0] r_key23;
    logic [pfe_pkg::KEY_ROW_W-1:0]  r_key4;

    logic             cfg_wr;
    pfe_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = pfe_pkg::t_reg_idx'(paddr[pfe_pkg::APB_ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key01 <= '0;
            r_key23 <= '0;
            r_key4  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                pfe_pkg::REG_ROWS01: r_key01 <= pwdata[pfe_pkg::KEY_PAIR_W-1:0];
                pfe_pkg::REG_ROWS23: r_key23 <= pwdata[pfe_pkg::KEY_PAIR_W-1:0];
                pfe_pkg::REG_ROW4:   r_key4  <= pwdata[pfe_pkg::KEY_ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            pfe_pkg::REG_ROWS01: prdata = pfe_pkg::APB_DATA_W'(r_key01);
            pfe_pkg::REG_ROWS23: prdata = pfe_pkg::APB_DATA_W'(r_key23);
            pfe_pkg::REG_ROW4:   prdata = pfe_pkg::APB_DATA_W'(r_key4);
            default:             prdata = '0;
        endcase
    end

    pfe_pkg::t_square square;
    assign square = pfe_pkg::t_square'({r_key4, r_key23, r_key01});

    // two-stage pipeline: input register, result register
    logic          r_in_valid;
    pfe_pkg::t_code r_in_first;
    pfe_pkg::t_code r_in_second;
    logic           r_out_valid;
    pfe_pkg::t_result r_out;

    logic             out_open;
    logic             in_accept;
    pfe_pkg::t_result n_out;

    assign out_open      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || out_open;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_first  <= s_axis_tdata[pfe_pkg::CODE_W-1:0];
            r_in_second <= s_axis_tdata[2*pfe_pkg::CODE_W-1:pfe_pkg::CODE_W];
        end
    end

    pfe_core u_core (
        .i_square (square),
        .i_first  (r_in_first),
        .i_second (r_in_second),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_open) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_open && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = pfe_pkg::TDATA_OUT_W'({r_out});

`ifndef SYNTHESIS
    // an item in the input stage moves to the result stage when it is open
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_open) |=> m_axis_tvalid)
        else $error("input stage item not advanced");

    // identical letters always report the identical-letter status
    a_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_open && (r_in_first == r_in_second))
        |=> (r_out.status == pfe_pkg::ST_SAME))
        else $error("identical pair not flagged");

    // cipher letters are zero on any error status
    a_zero_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out.status != pfe_pkg::ST_OK))
        |-> (r_out.first == '0) && (r_out.second == '0))
        else $error("cipher letters nonzero with error status");
`endif

endmodule

/* tb/tb_playfair_digraph_encrypt.sv */
`default_nettype none

module tb_playfair_digraph_encrypt;
    timeunit 1ns;
    timeprecision 1ps;

    import pfe_pkg::*;

    // Kinds of random key square; each random phase loads one.
    typedef enum int {
        SQ_ALPHA,   // 25 distinct letters a..z, one letter left out
        SQ_WIDE,    // 25 distinct codes out of 0..31
        SQ_DUPS,    // distinct codes, then a few cells overwritten by others
        SQ_NOISE    // every cell any code, duplicates everywhere
    } t_sq_kind;

    localparam int CELLS          = SIDE * SIDE;
    localparam int PHASE_ITEMS    = 240;
    localparam int RANDOM_PHASES  = 8;
    localparam int DRAIN_CYCLES   = 4;      // two register stages plus margin
    localparam int MAX_PRINTED    = 50;

    // Predicts the cipher pair for each accepted plaintext pair and holds
    // the predictions until the matching result item comes out.
    class pair_scoreboard;
        t_square key;
        t_result pending[$];
        int      errors;
        int      results_seen;

        function new();
            key          = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void set_key(input t_square sq);
            key = sq;
        endfunction

        task report_mismatch(input string what);
            if (errors < MAX_PRINTED) begin
                $display("%0t mismatch: %s", $realtime, what);
            end
            errors++;
        endtask

        // Last match in row-major order wins, as the square may repeat codes.
        function t_result encipher(input t_code a, input t_code b);
            t_result r;
            bit      hit_a;
            bit      hit_b;
            int      r1;
            int      c1;
            int      r2;
            int      c2;
            r.first  = '0;
            r.second = '0;
            r.status = ST_OK;
            hit_a = 1'b0;
            hit_b = 1'b0;
            r1 = 0; c1 = 0; r2 = 0; c2 = 0;
            if (a == b) begin
                r.status = ST_SAME;
                return r;
            end
            for (int row = 0; row < SIDE; row++) begin
                for (int col = 0; col < SIDE; col++) begin
                    if (key[row][col] == a) begin
                        hit_a = 1'b1; r1 = row; c1 = col;
                    end
                    if (key[row][col] == b) begin
                        hit_b = 1'b1; r2 = row; c2 = col;
                    end
                end
            end
            if (!(hit_a && hit_b)) begin
                r.status = ST_MISSING;
            end else if (r1 == r2) begin
                r.first  = key[r1][(c1 + 1) % SIDE];
                r.second = key[r2][(c2 + 1) % SIDE];
            end else if (c1 == c2) begin
                r.first  = key[(r1 + 1) % SIDE][c1];
                r.second = key[(r2 + 1) % SIDE][c2];
            end else begin
                r.first  = key[r1][c2];
                r.second = key[r2][c1];
            end
            return r;
        endfunction

        function void note_pair(input t_code a, input t_code b);
            pending.push_back(encipher(a, b));
        endfunction

        task check_result(input logic [TDATA_OUT_W-1:0] beat);
            t_result want;
            results_seen++;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("result %0d with no pair outstanding (data %h)",
                                          results_seen, beat));
                return;
            end
            want = pending.pop_front();
            if (beat[4:0] !== want.first) begin
                report_mismatch($sformatf("result %0d first_cipher %0d, want %0d",
                                          results_seen, beat[4:0], want.first));
            end
            if (beat[9:5] !== want.second) begin
                report_mismatch($sformatf("result %0d second_cipher %0d, want %0d",
                                          results_seen, beat[9:5], want.second));
            end
            if (beat[11:10] !== want.status) begin
                report_mismatch($sformatf("result %0d status %0d, want %0d",
                                          results_seen, beat[11:10], want.status));
            end
        endtask
    endclass

    // ---------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ---------------------------------------------------------------------
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr         = '0;
    logic [APB_DATA_W-1:0]  pwdata        = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [4:0] first_letter, [9:5] second_letter, [15:10] zero
    logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [4:0] first_cipher, [9:5] second_cipher, [11:10] status, [15:12] zero
    logic [TDATA_OUT_W-1:0] m_axis_tdata;

    pair_scoreboard sb = new();

    t_code square_cells [CELLS];   // key square currently loaded, row-major
    int    burst_left = 0;         // items left in the sender's current burst
    int    rx_left    = 0;         // cycles left in the receiver's current run
    bit    rx_hold    = 1'b0;      // current receiver run is a stall

    playfair_digraph_encrypt dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Generous cap: the slowest legal run is well under a tenth of this.
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Receiver: outputs are sampled right at the edge, so they hold their
    // pre-edge values; ready mixes stalls with short and long open runs.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
            end
            if (rx_left == 0) begin
                rx_hold = ($urandom_range(0, 99) < 30);
                if (rx_hold) begin
                    rx_left = $urandom_range(1, 8);
                end else if ($urandom_range(0, 9) == 0) begin
                    rx_left = $urandom_range(100, 300);
                end else begin
                    rx_left = $urandom_range(1, 20);
                end
            end
            rx_left--;
            m_axis_tready <= !rx_hold;
        end
    end

    // ---------------------------------------------------------------------
    // APB access: setup phase, then access phase until pready, then psel drops to end the bus cycle
    // ---------------------------------------------------------------------
    task automatic apb_write(input t_reg_idx idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(int'(idx) * 8);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(input t_reg_idx idx, input logic [APB_DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(int'(idx) * 8);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            sb.report_mismatch($sformatf("register %s reads %h, want %h",
                                         idx.name(), prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write the three key registers from square_cells, with junk above the
    // register width, then read each back (junk must be dropped).
    task automatic load_square();
        logic [SQUARE_W-1:0] flat;
        for (int n = 0; n < CELLS; n++) begin
            flat[n*CODE_W +: CODE_W] = square_cells[n];
        end
        apb_write(REG_ROWS01, {14'($urandom), flat[KEY_PAIR_W-1:0]});
        apb_write(REG_ROWS23, {14'($urandom), flat[2*KEY_PAIR_W-1:KEY_PAIR_W]});
        apb_write(REG_ROW4,   {39'($urandom), flat[SQUARE_W-1:2*KEY_PAIR_W]});
        apb_read_check(REG_ROWS01, APB_DATA_W'(flat[KEY_PAIR_W-1:0]));
        apb_read_check(REG_ROWS23, APB_DATA_W'(flat[2*KEY_PAIR_W-1:KEY_PAIR_W]));
        apb_read_check(REG_ROW4,   APB_DATA_W'(flat[SQUARE_W-1:2*KEY_PAIR_W]));
        sb.set_key(t_square'(flat));
    endtask

    task automatic fill_square(input t_sq_kind kind);
        t_code pool [32];
        t_code tmp;
        int    j;
        int    span;
        span = (kind == SQ_ALPHA) ? 26 : 32;
        for (int n = 0; n < 32; n++) begin
            pool[n] = t_code'(n);
        end
        // shuffle the usable codes, keep the first 25
        for (int n = span - 1; n > 0; n--) begin
            j = $urandom_range(0, n);
            tmp = pool[n]; pool[n] = pool[j]; pool[j] = tmp;
        end
        for (int n = 0; n < CELLS; n++) begin
            square_cells[n] = pool[n];
        end
        if (kind == SQ_DUPS) begin
            repeat ($urandom_range(1, 4)) begin
                square_cells[$urandom_range(0, CELLS - 1)] =
                    square_cells[$urandom_range(0, CELLS - 1)];
            end
        end else if (kind == SQ_NOISE) begin
            for (int n = 0; n < CELLS; n++) begin
                square_cells[n] = t_code'($urandom_range(0, 31));
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Sender: bursts of random length, random gaps; valid stays high across
    // a burst and is only lowered when a real gap follows.
    // ---------------------------------------------------------------------
    task automatic push_pair(input t_code a, input t_code b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {6'd0, b, a};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_pair(a, b);
    endtask

    // Mostly letters taken from the square (so row, column and rectangle
    // cases all show up), plus identical pairs and random codes that may lie off the square.
    task automatic push_random_pair();
        t_code a;
        t_code b;
        int    pick;
        pick = $urandom_range(0, 99);
        a = square_cells[$urandom_range(0, CELLS - 1)];
        b = square_cells[$urandom_range(0, CELLS - 1)];
        if (pick >= 70 && pick < 78) begin
            a = t_code'($urandom_range(0, 31));
            b = a;
        end else if (pick >= 78 && pick < 84) begin
            b = t_code'($urandom_range(0, 31));
        end else if (pick >= 84 && pick < 90) begin
            a = t_code'($urandom_range(0, 31));
        end else if (pick >= 90) begin
            a = t_code'($urandom_range(0, 31));
            b = t_code'($urandom_range(0, 31));
        end
        push_pair(a, b);
    endtask

    // Stop sending and wait for every predicted result, then let the
    // pipeline settle before the key may change.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // square still all zero from reset: only code 0 is present
        push_pair(5'd0, 5'd0);
        push_pair(5'd0, 5'd5);
        push_pair(5'd9, 5'd0);
        push_pair(5'd31, 5'd31);
        drain();

        // classic square built from a keyword, no j:
        //   p l a y f / i r e x m / b c d g h / k n o q s / t u v w z
        square_cells = '{5'd15, 5'd11, 5'd0,  5'd24, 5'd5,
                         5'd8,  5'd17, 5'd4,  5'd23, 5'd12,
                         5'd1,  5'd2,  5'd3,  5'd6,  5'd7,
                         5'd10, 5'd13, 5'd14, 5'd16, 5'd18,
                         5'd19, 5'd20, 5'd21, 5'd22, 5'd25};
        load_square();
        push_pair(5'd0,  5'd5);     // same row, second wraps to column 0
        push_pair(5'd11, 5'd24);    // same row
        push_pair(5'd15, 5'd19);    // same column, bottom wraps to top
        push_pair(5'd12, 5'd25);    // same column, last column
        push_pair(5'd15, 5'd12);    // rectangle
        push_pair(5'd7,  5'd8);     // rectangle, other orientation
        push_pair(5'd4,  5'd4);     // identical letters
        push_pair(5'd9,  5'd9);     // identical and absent: identical wins
        push_pair(5'd9,  5'd0);     // first letter absent
        push_pair(5'd0,  5'd9);     // second letter absent
        push_pair(5'd26, 5'd31);    // both beyond z, absent
        push_pair(5'd0,  5'd25);    // a and z
        push_pair(5'd25, 5'd0);
        drain();

        // repeated code (last match counts) and codes above z in the square
        square_cells[6]  = 5'd0;
        square_cells[20] = 5'd26;
        square_cells[24] = 5'd31;
        load_square();
        push_pair(5'd0,  5'd11);
        push_pair(5'd0,  5'd4);
        push_pair(5'd31, 5'd15);
        push_pair(5'd31, 5'd26);
        push_pair(5'd20, 5'd26);
        drain();

        // every register at its maximum: all cells hold 31
        foreach (square_cells[n]) square_cells[n] = 5'd31;
        load_square();
        push_pair(5'd31, 5'd31);
        push_pair(5'd31, 5'd0);
        push_pair(5'd0,  5'd31);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            fill_square(t_sq_kind'(p % 4));
            load_square();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // one pause mid-phase until the output side has caught up
                if (p == 2 && k == PHASE_ITEMS / 2) begin
                    drain();
                end
                push_random_pair();
            end
            drain();
        end

        // back to an all-zero square written explicitly
        foreach (square_cells[n]) square_cells[n] = 5'd0;
        load_square();
        repeat (20) push_random_pair();
        drain();

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
sv/pfe_pkg.sv
sv/pfe_locate.sv
sv/pfe_core.sv
sv/playfair_digraph_encrypt.sv
tb/tb_playfair_digraph_encrypt.sv
